// File: rtl/kvrc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the record checker.
// Used by every module of the block; depends on nothing.
package kvrc_pkg;

    localparam int POS_W = 34;
    localparam int VS_W = 17;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] REC_MAGIC = 8'hFA;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam int MIN_LEN = 7;
    localparam int CRC_BYTES = 4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_KEY_TRUNC = 3'd3;
    localparam logic [2:0] ST_VALUE_TRUNC = 3'd4;
    localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One classified byte, handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       emit_value;
        logic       crc_en;
        logic       chk_en;
        logic [1:0] chk_lane;
        logic       last;
        logic [2:0] status;
        logic       check_crc;
    } kvrc_op_t;

    // Reflected CRC-32, one byte: eight shift-and-xor steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/kv_record_checker_crc32.sv
// Record checker: takes one record byte per cycle on the byte channel while byte_ready
// is high and returns value bytes and one closing status per record on the result
// channel. Sustained rate is one byte per cycle while the result side takes every
// result; a record whose last byte is a value byte also needs an output slot of its own
// for its status. With no stall, a byte's results pass through the classify queue and
// then the result register; the classify queue (QUEUE_DEPTH entries) lets the input
// keep flowing while the result side stalls, until it fills. Value bytes of a bad record
// are still delivered and should be dropped unless the closing status is ok (0).
module kv_record_checker_crc32 #(
    parameter int QUEUE_DEPTH = kvrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       kind,
    output logic [7:0] value_byte,
    output logic [2:0] status,
    output logic       end_of_record
);
    import kvrc_pkg::*;

    kvrc_op_t front_op;
    kvrc_op_t q_op;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     push;

    assign byte_ready = !q_full;
    assign push = byte_valid && !q_full;

    kvrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push),
        .op         (front_op)
    );

    kvrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_op    (front_op),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_op    (q_op)
    );

    kvrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .value_byte    (value_byte),
        .status        (status),
        .end_of_record (end_of_record)
    );

endmodule

// File: rtl/kvrc_front.sv
// Front end of the record checker: tracks the byte position and the length fields,
// classifies each byte and decides every status except the CRC check. Uses kvrc_pkg.
module kvrc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    input  logic               push,
    output kvrc_pkg::kvrc_op_t op
);
    import kvrc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      kl_reg, kl_next;
    logic [VS_W-1:0]  vs_reg, vs_next;
    logic [31:0]      vl_reg, vl_next;
    logic [POS_W-1:0] ve_reg, ve_next;
    logic             magic_reg, magic_next;

    logic             p0, p1, p2, p_hdr;
    logic [VS_W-1:0]  vs_m4;
    logic             ge_vs4, ge_vs, ge_ve;
    logic [POS_W-1:0] d_ve;
    logic             in_vlen, in_val, in_chk;
    logic [1:0]       vl_lane;
    logic [POS_W:0]   len;
    logic             val_trunc;

    always_comb
    begin
        p0 = (pos_reg == POS_W'(0));
        p1 = (pos_reg == POS_W'(1));
        p2 = (pos_reg == POS_W'(2));
        p_hdr = p0 || p1 || p2;
        vs_m4 = vs_reg - VS_W'(4);
        ge_vs4 = (pos_reg >= {{(POS_W-VS_W){1'b0}}, vs_m4});
        ge_vs = (pos_reg >= {{(POS_W-VS_W){1'b0}}, vs_reg});
        ge_ve = (pos_reg >= ve_reg);
        d_ve = pos_reg - ve_reg;
        in_vlen = !p_hdr && ge_vs4 && !ge_vs;
        in_val = !p_hdr && ge_vs && !ge_ve;
        in_chk = !p_hdr && ge_vs && ge_ve && (d_ve < POS_W'(CRC_BYTES));
        vl_lane = pos_reg[1:0] - vs_reg[1:0];
        len = {1'b0, pos_reg} + (POS_W+1)'(1);
        // The end of the value is final once the position reaches it, so the
        // value field is short exactly when the CRC bytes do not all fit.
        val_trunc = !ge_vs || !ge_ve || (d_ve < POS_W'(CRC_BYTES - 1));

        op.data = data_byte;
        op.emit_value = in_val;
        op.crc_en = !p0 && !(ge_vs && ge_ve);
        op.chk_en = in_chk;
        op.chk_lane = d_ve[1:0];
        op.last = final_byte;
        op.check_crc = 1'b0;
        if (pos_reg < POS_W'(MIN_LEN - 1))
        begin
            op.status = ST_TOO_SHORT;
        end
        else if (!magic_reg)
        begin
            op.status = ST_BAD_MAGIC;
        end
        else if (len < {{(POS_W+1-VS_W){1'b0}}, vs_reg})
        begin
            op.status = ST_KEY_TRUNC;
        end
        else if (val_trunc)
        begin
            op.status = ST_VALUE_TRUNC;
        end
        else
        begin
            op.status = ST_OK;
            op.check_crc = 1'b1;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        kl_next = kl_reg;
        vs_next = vs_reg;
        vl_next = vl_reg;
        ve_next = ve_reg;
        magic_next = magic_reg;
        if (push)
        begin
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (p0)
            begin
                magic_next = (data_byte == REC_MAGIC);
            end
            else if (p1)
            begin
                kl_next = {8'b0, data_byte};
            end
            else if (p2)
            begin
                kl_next = {data_byte, kl_reg[7:0]};
                vs_next = VS_W'(MIN_LEN) + {1'b0, data_byte, kl_reg[7:0]};
                ve_next = {{(POS_W-VS_W){1'b0}}, vs_next};
            end
            else if (in_vlen)
            begin
                case (vl_lane)
                    2'd0: vl_next = vl_reg | {24'b0, data_byte};
                    2'd1: vl_next = vl_reg | {16'b0, data_byte, 8'b0};
                    2'd2: vl_next = vl_reg | {8'b0, data_byte, 16'b0};
                    2'd3: vl_next = vl_reg | {data_byte, 24'b0};
                    default: vl_next = vl_reg;
                endcase
                ve_next = {{(POS_W-VS_W){1'b0}}, vs_reg} + {{(POS_W-32){1'b0}}, vl_next};
            end
            if (final_byte)
            begin
                pos_next = '0;
                kl_next = '0;
                vs_next = VS_W'(MIN_LEN);
                vl_next = '0;
                ve_next = POS_W'(MIN_LEN);
                magic_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            kl_reg <= '0;
            vs_reg <= VS_W'(MIN_LEN);
            vl_reg <= '0;
            ve_reg <= POS_W'(MIN_LEN);
            magic_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            kl_reg <= kl_next;
            vs_reg <= vs_next;
            vl_reg <= vl_next;
            ve_reg <= ve_next;
            magic_reg <= magic_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && final_byte) |=> (pos_reg == '0 && vl_reg == '0))
        else $error("front end did not restart after the last byte of a record");

    a_value_after_length: assert property (@(posedge clk) disable iff (!rst_n)
        (push && op.emit_value) |-> (!p_hdr && ve_reg > {{(POS_W-VS_W){1'b0}}, vs_reg} - POS_W'(1)))
        else $error("value byte classified before the value length was known");

endmodule

// File: rtl/kvrc_queue.sv
// Short queue of classified bytes between the front and back ends of the checker.
// Register-based, one write and one read per cycle. Uses kvrc_pkg.
module kvrc_queue #(
    parameter int DEPTH = kvrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kvrc_pkg::kvrc_op_t wr_op,
    output logic               full,
    input  logic               pop,
    output logic               rd_valid,
    output kvrc_pkg::kvrc_op_t rd_op
);
    import kvrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kvrc_op_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

// File: rtl/kvrc_back.sv
// Back end of the record checker: runs the CRC, gathers the stored checksum and
// drives the result register, at most two results per record byte. Uses kvrc_pkg.
module kvrc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  kvrc_pkg::kvrc_op_t q_op,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               kind,
    output logic [7:0]         value_byte,
    output logic [2:0]         status,
    output logic               end_of_record
);
    import kvrc_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [31:0] chk_reg, chk_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic        pend_reg, pend_next;
    logic [2:0]  pend_status_reg, pend_status_next;

    logic        slot_free;
    logic [31:0] crc_upd;
    logic [2:0]  final_status;

    assign slot_free = !out_valid_reg || result_ready;
    assign pop = q_valid && slot_free && !pend_reg;

    always_comb
    begin
        crc_upd = q_op.crc_en ? crc_byte(crc_reg, q_op.data) : crc_reg;
        chk_next = chk_reg;
        if (q_op.chk_en)
        begin
            case (q_op.chk_lane)
                2'd0: chk_next = chk_reg | {24'b0, q_op.data};
                2'd1: chk_next = chk_reg | {16'b0, q_op.data, 8'b0};
                2'd2: chk_next = chk_reg | {8'b0, q_op.data, 16'b0};
                2'd3: chk_next = chk_reg | {q_op.data, 24'b0};
                default: chk_next = chk_reg;
            endcase
        end
        if (q_op.check_crc && ((crc_upd ^ CRC_ONES) != chk_next))
        begin
            final_status = ST_CRC_MISMATCH;
        end
        else
        begin
            final_status = q_op.status;
        end
        crc_next = crc_upd;
        if (q_op.last)
        begin
            crc_next = CRC_ONES;
            chk_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next = out_kind_reg;
        out_byte_next = out_byte_reg;
        out_status_next = out_status_reg;
        pend_next = pend_reg;
        pend_status_next = pend_status_reg;
        if (pend_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next = KIND_STATUS;
            out_byte_next = '0;
            out_status_next = pend_status_reg;
            pend_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = q_op.emit_value || q_op.last;
            if (q_op.emit_value)
            begin
                out_kind_next = KIND_VALUE;
                out_byte_next = q_op.data;
                out_status_next = ST_OK;
                // A last byte that is itself a value byte: the status follows.
                pend_next = q_op.last;
                pend_status_next = final_status;
            end
            else
            begin
                out_kind_next = KIND_STATUS;
                out_byte_next = '0;
                out_status_next = final_status;
            end
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_ONES;
            chk_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg <= crc_next;
                chk_reg <= chk_next;
            end
            out_valid_reg <= out_valid_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_status_reg <= out_status_next;
        pend_status_reg <= pend_status_next;
    end

    assign result_valid = out_valid_reg;
    assign kind = out_kind_reg;
    assign value_byte = out_byte_reg;
    assign status = out_status_reg;
    assign end_of_record = out_kind_reg;

    a_pend_behind_value: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && out_kind_reg == KIND_VALUE))
        else $error("pending status without a value result ahead of it");

    a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_op.emit_value && q_op.last) |=> pend_reg)
        else $error("status of a record ending on a value byte was dropped");

endmodule

// File: test/kv_record_checker_crc32_tb.sv
// Testbench for kv_record_checker_crc32: streams directed and random records through
// the byte channel and checks every value byte and closing status against a predictor.
// Depends on kvrc_pkg (status and kind codes, magic byte, CRC polynomial).

module kv_record_checker_crc32_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kvrc_pkg::*;

    // Tracks the record parser state and holds the results each accepted byte should cause.
    class record_scoreboard;

        typedef struct {
            logic       kind;
            logic [7:0] value;
            logic [2:0] status;
            logic       eor;
        } result_t;

        result_t     expected_q[$];
        int          errors;
        logic [33:0] pos;
        logic [15:0] key_len;
        logic [31:0] val_len;
        logic [31:0] crc;
        logic [31:0] crc_field;
        logic        magic_ok;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos = '0;
            key_len = '0;
            val_len = '0;
            crc = CRC_ONES;
            crc_field = '0;
            magic_ok = 1'b0;
        endfunction

        // Bit-serial reflected CRC-32: each data bit, LSB first, is folded into the feedback.
        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                r = (r >> 1) ^ ({32{r[0] ^ b[i]}} & CRC_POLY);
            end
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void expect_result(logic k, logic [7:0] v, logic [2:0] s, logic e);
            result_t item;
            item.kind = k;
            item.value = v;
            item.status = s;
            item.eor = e;
            expected_q = {expected_q, item};
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            logic [35:0] p;
            logic [35:0] vstart;
            logic [35:0] vend;
            logic [35:0] len;
            logic [2:0]  st;
            int          lane;
            p = {2'b00, pos};
            vstart = 36'(MIN_LEN) + {20'b0, key_len};
            vend = vstart + {4'b0, val_len};
            if (p == 0)
                magic_ok = (b == REC_MAGIC);
            else if (p == 1)
                key_len = {8'h00, b};
            else if (p == 2)
                key_len[15:8] = b;
            else if (p >= vstart - 4 && p < vstart)
            begin
                lane = int'(p - (vstart - 4));
                val_len[8*lane +: 8] = b;
            end
            else if (p >= vstart && p < vend)
                expect_result(KIND_VALUE, b, ST_OK, 1'b0);
            else if (p >= vend && p < vend + CRC_BYTES)
            begin
                lane = int'(p - vend);
                crc_field[8*lane +: 8] = b;
            end

            // The CRC spans the key length through the last value byte.
            if (p >= 1 && p < vend)
                crc = crc_step(crc, b);

            if (pos != '1)
                pos = pos + 1'b1;

            if (fin)
            begin
                len = p + 1;
                if (len < MIN_LEN)
                    st = ST_TOO_SHORT;
                else if (!magic_ok)
                    st = ST_BAD_MAGIC;
                else if (36'(MIN_LEN) + {20'b0, key_len} > len)
                    st = ST_KEY_TRUNC;
                else if (36'(MIN_LEN + CRC_BYTES) + {20'b0, key_len} + {4'b0, val_len} > len)
                    st = ST_VALUE_TRUNC;
                else if ((crc ^ CRC_ONES) != crc_field)
                    st = ST_CRC_MISMATCH;
                else
                    st = ST_OK;
                expect_result(KIND_STATUS, 8'h00, st, 1'b1);
                restart();
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic k, logic [7:0] v, logic [2:0] s, logic e);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, %s %0h %0h %0h %0h",
                         $time, "actual kind, value, status, end", k, v, s, e);
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", {7'b0, want.kind}, {7'b0, k});
            compare_field("value_byte", want.value, v);
            compare_field("status", {5'b0, want.status}, {5'b0, s});
            compare_field("end_of_record", {7'b0, want.eor}, {7'b0, e});
        endfunction

    endclass

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 1200;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       result_valid;
    logic       result_ready;
    logic       kind;
    logic [7:0] value_byte;
    logic [2:0] status;
    logic       end_of_record;

    record_scoreboard sb;
    logic [7:0]       rec_q[$];
    int               bytes_sent;
    int               cycle_count;

    kv_record_checker_crc32 DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value_byte   (value_byte),
        .status       (status),
        .end_of_record(end_of_record)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("kv_record_checker_crc32_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(kind, value_byte, status, end_of_record);
    end

    // Result side: stall patterns from single cycles to long holds, with long open stretches.
    initial
    begin : result_side
        int hold;
        int r;
        logic level;
        hold = 0;
        level = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    level = 1'b1;
                    hold = $urandom_range(1, 8);
                end
                else if (r < 60)
                begin
                    level = 1'b1;
                    hold = $urandom_range(20, 80);
                end
                else if (r < 95)
                begin
                    level = 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
            result_ready <= level;
            hold--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Holds valid and payload steady from the falling edge until the transfer.
    task automatic send_byte(input logic [7:0] d, input logic fin, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= d;
        final_byte <= fin;
        do @(posedge clk); while (!byte_ready);
        sb.note_byte(d, fin);
        bytes_sent++;
    endtask

    task automatic send_record(input bit no_gaps);
        for (int i = 0; i < rec_q.size(); i++)
        begin
            send_byte(rec_q[i], i == rec_q.size() - 1, no_gaps);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    function automatic void append_byte(input logic [7:0] b);
        rec_q = {rec_q, b};
    endfunction

    task automatic push_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            append_byte(v[8*i +: 8]);
        end
    endtask

    // Builds a well-formed record with random key and value bytes and a correct CRC.
    task automatic build_record(input int klen, input int vlen);
        logic [31:0] c;
        rec_q.delete();
        append_byte(REC_MAGIC);
        push_le(klen, 2);
        repeat (klen) append_byte(8'($urandom_range(0, 255)));
        push_le(vlen, 4);
        repeat (vlen) append_byte(8'($urandom_range(0, 255)));
        c = CRC_ONES;
        for (int i = 1; i < rec_q.size(); i++)
        begin
            c = crc_byte(c, rec_q[i]);
        end
        push_le(c ^ CRC_ONES, CRC_BYTES);
    endtask

    function automatic int pick_key_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 4);
        else if (r < 95)
            return $urandom_range(5, 16);
        else
            return $urandom_range(17, 40);
    endfunction

    function automatic int pick_value_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, 48);
        else
            return $urandom_range(0, 12);
    endfunction

    task automatic random_record();
        int shape;
        int n;
        shape = $urandom_range(0, 99);
        build_record(pick_key_len(), pick_value_len());
        if (shape < 62)
        begin
            // Bytes past the CRC must be ignored.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
        end
        else if (shape < 72)
        begin
            n = $urandom_range(1, rec_q.size() - 1);
            rec_q[n] = rec_q[n] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (shape < 82)
        begin
            n = $urandom_range(1, rec_q.size() - 1);
            while (rec_q.size() > n) void'(rec_q.pop_back());
        end
        else if (shape < 88)
            rec_q[0] = rec_q[0] ^ 8'($urandom_range(1, 255));
        else if (shape < 94)
        begin
            n = $urandom_range(1, 24);
            rec_q.delete();
            repeat (n) append_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
                rec_q[0] = REC_MAGIC;
        end
        else
        begin
            // Random length fields, usually far past the end of the record.
            rec_q[$urandom_range(1, 2)] = 8'($urandom_range(0, 255));
            rec_q[$urandom_range(3, 6)] = 8'($urandom_range(0, 255));
        end
        send_record($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        sb = new();
        bytes_sent = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        data_byte = 8'h00;
        final_byte = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single byte is too short to hold a header.
        rec_q = '{REC_MAGIC};
        send_record(1'b0);
        // The largest key length cannot fit in a seven byte record.
        rec_q = '{REC_MAGIC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        send_record(1'b0);
        // The record ends on a value byte: the byte comes out, then the status.
        rec_q = '{REC_MAGIC, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_record(1'b1);
        // Empty key and value, one stray byte after the CRC.
        build_record(0, 0);
        append_byte(8'hFF);
        send_record(1'b0);
        drain_results();

        while (bytes_sent < RANDOM_BYTES)
        begin
            random_record();
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("kv_record_checker_crc32_tb passed");
        else
            $display("kv_record_checker_crc32_tb failed");
        $finish;
    end

endmodule
